// ----- sv/rpd_pkg.sv -----
// Package for the record pool draw engine: field widths, record and result types,
// status codes and controller states. No dependencies; every other file depends on it.
package rpd_pkg;

  localparam int unsigned ID_W           = 32;
  localparam int unsigned RATING_W       = 7;
  localparam int unsigned TIME_W         = 32;
  localparam int unsigned RAND_W         = 32;
  localparam int unsigned REMAIN_W       = 13;
  localparam int unsigned STEP_W         = $clog2(RAND_W + 1);
  localparam int unsigned DEF_POOL_DEPTH = 4096;

  localparam logic ACT_LOAD = 1'b0;
  localparam logic ACT_DRAW = 1'b1;

  typedef enum logic [1:0] {
    ST_LOADED = 2'd0,
    ST_DRAWN  = 2'd1,
    ST_FULL   = 2'd2,
    ST_EMPTY  = 2'd3
  } status_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DIV,
    S_SLOT,
    S_MOVE,
    S_RESP
  } state_e;

  typedef struct packed {
    logic [ID_W-1:0]     user;
    logic [ID_W-1:0]     item;
    logic [RATING_W-1:0] rating;
    logic [TIME_W-1:0]   stamp;
  } rec_t;

  typedef struct packed {
    status_e             status;
    rec_t                rec;
    logic [REMAIN_W-1:0] remaining;
  } result_t;

endpackage

// ----- sv/rpd_if.sv -----
// Valid/ready channel interfaces for the record pool draw engine.
// Depends on rpd_pkg for the field widths.
interface rpd_in_if;
  logic                         valid;
  logic                         ready;
  logic                         action;
  logic [rpd_pkg::ID_W-1:0]     user_id;
  logic [rpd_pkg::ID_W-1:0]     item_id;
  logic [rpd_pkg::RATING_W-1:0] rating_tenths;
  logic [rpd_pkg::TIME_W-1:0]   record_time;
  logic [rpd_pkg::RAND_W-1:0]   random_value;

  modport source (output valid, action, user_id, item_id, rating_tenths, record_time,
                  random_value, input ready);
  modport sink   (input valid, action, user_id, item_id, rating_tenths, record_time,
                  random_value, output ready);
endinterface

interface rpd_out_if;
  logic                         valid;
  logic                         ready;
  logic [1:0]                   status;
  logic [rpd_pkg::ID_W-1:0]     user_out;
  logic [rpd_pkg::ID_W-1:0]     item_out;
  logic [rpd_pkg::RATING_W-1:0] rating_out;
  logic [rpd_pkg::TIME_W-1:0]   time_out;
  logic [rpd_pkg::REMAIN_W-1:0] remaining;

  modport source (output valid, status, user_out, item_out, rating_out, time_out,
                  remaining, input ready);
  modport sink   (input valid, status, user_out, item_out, rating_out, time_out,
                  remaining, output ready);
endinterface

// ----- sv/record_pool_random_draw.sv -----
// Top level of the record pool draw engine: pool memory, controller and result register.
// Depends on rpd_pkg, the rpd_in_if/rpd_out_if interfaces and the rpd_div remainder unit.
//
//   Channel   Dir  Transaction contents
//   in_if     in   action, user_id, item_id, rating_tenths, record_time, random_value
//   out_if    out  status, user_out, item_out, rating_out, time_out, remaining
//
// A load goes through the result register into the output register. A draw first takes
// 32 remainder steps, a read of the chosen slot, a read of the last slot (one read port
// serializes them), the hole fill and the transfer. Input is taken again the cycle after
// the transfer. Reset clears only the live count and the control state, output valid
// flag included. A stalled result holds in the output register; the block finishes the
// next transaction up to its response and waits there until that register frees up.
module record_pool_random_draw #(
  parameter int unsigned POOL_DEPTH = rpd_pkg::DEF_POOL_DEPTH
) (
  input  logic clk_i,
  input  logic rst_ni,
  rpd_in_if.sink    in_if,
  rpd_out_if.source out_if
);
  import rpd_pkg::*;

  // The count must hold POOL_DEPTH itself; addresses only reach POOL_DEPTH-1.
  localparam int unsigned CNT_W  = $clog2(POOL_DEPTH + 1);
  localparam int unsigned ADDR_W = $clog2(POOL_DEPTH);

  state_e              state_q, state_d;
  logic [CNT_W-1:0]    count_q, count_d;
  logic [ADDR_W-1:0]   slot_q, slot_d;
  result_t             res_q, res_d;
  result_t             out_q;
  logic                out_valid_q;
  logic                out_load;

  // Pool memory: one write port, one registered read port.
  rec_t                mem_q [POOL_DEPTH];
  logic                we;
  logic [ADDR_W-1:0]   wa;
  rec_t                wd;
  logic                rd_en;
  logic [ADDR_W-1:0]   rd_addr;
  rec_t                rd_data_q;

  logic                accept;
  logic                pool_full;
  logic                div_start;
  logic                div_done;
  logic [CNT_W-1:0]    div_rem;
  logic [CNT_W-1:0]    count_dec;
  logic [CNT_W-1:0]    count_inc;

  rpd_div #(
    .CNT_W (CNT_W)
  ) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (in_if.random_value),
    .divisor_i  (count_q),
    .done_o     (div_done),
    .rem_o      (div_rem)
  );

  assign in_if.ready = (state_q == S_IDLE);
  assign accept      = in_if.valid && in_if.ready;
  assign pool_full   = (count_q == CNT_W'(POOL_DEPTH));
  assign count_dec   = count_q - 1'b1;
  assign count_inc   = count_q + 1'b1;

  always_comb begin
    state_d   = state_q;
    count_d   = count_q;
    slot_d    = slot_q;
    res_d     = res_q;
    we        = 1'b0;
    wa        = count_q[ADDR_W-1:0];
    wd        = '{user:   in_if.user_id,
                  item:   in_if.item_id,
                  rating: in_if.rating_tenths,
                  stamp:  in_if.record_time};
    rd_en     = 1'b0;
    rd_addr   = div_rem[ADDR_W-1:0];
    div_start = 1'b0;
    out_load  = 1'b0;
    case (state_q)
      S_IDLE: begin
        if (accept) begin
          res_d.rec = '0;
          if (in_if.action == ACT_LOAD) begin
            if (pool_full) begin
              // Dropped load: the pool is untouched.
              res_d.status    = ST_FULL;
              res_d.remaining = REMAIN_W'(32'(count_q));
            end else begin
              we              = 1'b1;
              count_d         = count_inc;
              res_d.status    = ST_LOADED;
              res_d.remaining = REMAIN_W'(32'(count_inc));
            end
            state_d = S_RESP;
          end else if (count_q == '0) begin
            res_d.status    = ST_EMPTY;
            res_d.remaining = '0;
            state_d         = S_RESP;
          end else begin
            div_start = 1'b1;
            state_d   = S_DIV;
          end
        end
      end
      S_DIV: begin
        if (div_done) begin
          // The remainder is below the count, so it fits the address width.
          rd_en   = 1'b1;
          rd_addr = div_rem[ADDR_W-1:0];
          slot_d  = div_rem[ADDR_W-1:0];
          state_d = S_SLOT;
        end
      end
      S_SLOT: begin
        // The drawn record arrives; fetch the last live record next.
        res_d.status = ST_DRAWN;
        res_d.rec    = rd_data_q;
        rd_en        = 1'b1;
        rd_addr      = count_dec[ADDR_W-1:0];
        state_d      = S_MOVE;
      end
      S_MOVE: begin
        // Fill the hole with the last record. When the drawn slot is the last one
        // this rewrites it with itself, which lies beyond the shrunken pool anyway.
        we              = 1'b1;
        wa              = slot_q;
        wd              = rd_data_q;
        count_d         = count_dec;
        res_d.remaining = REMAIN_W'(32'(count_dec));
        state_d         = S_RESP;
      end
      S_RESP: begin
        if (!out_valid_q || out_if.ready) begin
          out_load = 1'b1;
          state_d  = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      count_q <= '0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    slot_q <= slot_d;
    res_q  <= res_d;
  end

  always_ff @(posedge clk_i) begin
    if (we) begin
      mem_q[wa] <= wd;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en) begin
      rd_data_q <= mem_q[rd_addr];
    end
  end

  // Output register: holds a finished result until the sink takes it.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
    end else if (out_if.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_q <= res_q;
    end
  end

  assign out_if.valid      = out_valid_q;
  assign out_if.status     = out_q.status;
  assign out_if.user_out   = out_q.rec.user;
  assign out_if.item_out   = out_q.rec.item;
  assign out_if.rating_out = out_q.rec.rating;
  assign out_if.time_out   = out_q.rec.stamp;
  assign out_if.remaining  = out_q.remaining;

  // The live count never exceeds the pool size.
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CNT_W'(POOL_DEPTH))
    else $error("live count above pool depth");

  // The move step shrinks the pool by exactly one record.
  a_move_shrinks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_MOVE |=> count_q == $past(count_dec))
    else $error("draw did not shrink the pool by one");

  // The remainder unit only finishes while the controller waits for it.
  a_div_owned: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_done |-> state_q == S_DIV)
    else $error("remainder unit finished outside a draw");

  // A drawn slot always lies inside the live pool.
  a_slot_live: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_SLOT |-> CNT_W'(slot_q) < count_q)
    else $error("drawn slot outside the live pool");

endmodule

// ----- sv/rpd_div.sv -----
// Bit-serial remainder unit: random word modulo the live count, one bit per cycle.
// Depends on rpd_pkg for the random word width and step counter width.
module rpd_div #(
  parameter int unsigned CNT_W = 13
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       start_i,
  input  logic [rpd_pkg::RAND_W-1:0] dividend_i,
  input  logic [CNT_W-1:0]           divisor_i,
  output logic                       done_o,
  output logic [CNT_W-1:0]           rem_o
);
  import rpd_pkg::*;

  logic              busy_q, busy_d;
  logic              done_q, done_d;
  logic [STEP_W-1:0] step_q, step_d;
  logic [RAND_W-1:0] dvd_q, dvd_d;
  logic [CNT_W-1:0]  dsr_q, dsr_d;
  logic [CNT_W-1:0]  rem_q, rem_d;
  logic [CNT_W:0]    shifted;
  logic [CNT_W:0]    diff;

  // Restoring step: the partial remainder stays below the divisor, so one
  // compare-and-subtract per bit keeps it in range.
  assign shifted = {rem_q, dvd_q[RAND_W-1]};
  assign diff    = shifted - {1'b0, dsr_q};

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    step_d = step_q;
    dvd_d  = dvd_q;
    dsr_d  = dsr_q;
    rem_d  = rem_q;
    if (start_i) begin
      busy_d = 1'b1;
      step_d = '0;
      dvd_d  = dividend_i;
      dsr_d  = divisor_i;
      rem_d  = '0;
    end else if (busy_q) begin
      dvd_d  = {dvd_q[RAND_W-2:0], 1'b0};
      rem_d  = diff[CNT_W] ? shifted[CNT_W-1:0] : diff[CNT_W-1:0];
      step_d = step_q + 1'b1;
      if (step_q == STEP_W'(RAND_W - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      step_q <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      step_q <= step_d;
    end
  end

  always_ff @(posedge clk_i) begin
    dvd_q <= dvd_d;
    dsr_q <= dsr_d;
    rem_q <= rem_d;
  end

  assign done_o = done_q;
  assign rem_o  = rem_q;

endmodule

// ----- sim/record_pool_random_draw_tb.sv -----
// Self-checking testbench for record_pool_random_draw: random load/draw traffic with a
// cycle-free pool predictor, randomized source gaps and sink stalls, and a watchdog.
// Depends on rpd_pkg, the rpd_in_if/rpd_out_if interfaces and the record_pool_random_draw RTL.
module record_pool_random_draw_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import rpd_pkg::*;

  localparam int unsigned POOL_DEPTH     = DEF_POOL_DEPTH;
  // A correct block, even with the longest source gap and sink stall around a draw,
  // never comes near this limit without completing a transaction.
  localparam int unsigned WATCHDOG_LIMIT = 2000;
  localparam int unsigned TAIL_CYCLES    = 40;
  localparam int unsigned RANDOM_OPS     = 1500;

  // Gap styles used when the stimulus is built.
  localparam int unsigned GAP_NONE   = 0;
  localparam int unsigned GAP_RANDOM = 1;
  localparam int unsigned GAP_SPARSE = 2;

  // One pending operation on the input channel, with the idle cycles that precede it
  // and a flag that makes the source wait until every result has come back first.
  typedef struct packed {
    logic                action;
    logic [ID_W-1:0]     user;
    logic [ID_W-1:0]     item;
    logic [RATING_W-1:0] rating;
    logic [TIME_W-1:0]   stamp;
    logic [RAND_W-1:0]   rnd;
    logic [3:0]          gap;
    logic                drain;
  } pool_op_t;

  logic clk   = 1'b0;
  logic rst_n = 1'b0;

  rpd_in_if  in_ch ();
  rpd_out_if out_ch ();

  // The channel inputs are driven from these registers, which are known from time zero.
  pool_op_t drive_op    = '0;
  logic     drive_valid = 1'b0;
  logic     sink_ready  = 1'b0;

  assign in_ch.valid         = drive_valid;
  assign in_ch.action        = drive_op.action;
  assign in_ch.user_id       = drive_op.user;
  assign in_ch.item_id       = drive_op.item;
  assign in_ch.rating_tenths = drive_op.rating;
  assign in_ch.record_time   = drive_op.stamp;
  assign in_ch.random_value  = drive_op.rnd;
  assign out_ch.ready        = sink_ready;

  record_pool_random_draw #(
    .POOL_DEPTH(POOL_DEPTH)
  ) dut (
    .clk_i (clk),
    .rst_ni(rst_n),
    .in_if (in_ch),
    .out_if(out_ch)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Pool predictor. It keeps its own copy of the records and the live count and
  // applies each accepted transaction in acceptance order.
  // ---------------------------------------------------------------------------
  rec_t        model_pool [POOL_DEPTH];
  int unsigned model_live = 0;

  function automatic result_t pool_apply(pool_op_t op);
    result_t     r;
    int unsigned slot;
    r = '0;
    if (op.action == ACT_LOAD) begin
      if (model_live >= POOL_DEPTH) begin
        // A full pool drops the record and keeps its count.
        r.status = ST_FULL;
      end else begin
        model_pool[model_live] = '{user: op.user, item: op.item, rating: op.rating,
                                   stamp: op.stamp};
        model_live++;
        r.status = ST_LOADED;
      end
    end else if (model_live == 0) begin
      r.status = ST_EMPTY;
    end else begin
      // Pick the slot, hand out its record and fill the hole with the last record.
      slot              = op.rnd % model_live;
      r.rec             = model_pool[slot];
      model_pool[slot]  = model_pool[model_live-1];
      model_live--;
      r.status          = ST_DRAWN;
    end
    r.remaining = model_live[REMAIN_W-1:0];
    return r;
  endfunction

  pool_op_t    stim_items [$];
  result_t     pool_replies [$];
  int unsigned ops_total    = 0;
  int unsigned ops_accepted = 0;
  int unsigned results_seen = 0;
  int unsigned mismatches   = 0;
  int unsigned idle_cycles  = 0;
  logic        timed_out    = 1'b0;

  // ---------------------------------------------------------------------------
  // Stimulus construction. gen_live mirrors the pool size so that the generator
  // can steer the traffic towards the empty corner.
  // ---------------------------------------------------------------------------
  int unsigned gen_live = 0;
  int unsigned gap_mode = GAP_RANDOM;

  task automatic push_op(input logic act, input logic [ID_W-1:0] user,
                         input logic [ID_W-1:0] item, input logic [RATING_W-1:0] rating,
                         input logic [TIME_W-1:0] stamp, input logic [RAND_W-1:0] rnd,
                         input logic drain);
    pool_op_t op;
    op.action = act;
    op.user   = user;
    op.item   = item;
    op.rating = rating;
    op.stamp  = stamp;
    op.rnd    = rnd;
    op.drain  = drain;
    case (gap_mode)
      GAP_NONE:   op.gap = 4'd0;
      GAP_SPARSE: op.gap = ($urandom_range(0, 7) == 0) ? 4'($urandom_range(0, 15)) : 4'd0;
      default:    op.gap = 4'($urandom_range(0, 15));
    endcase
    stim_items.push_back(op);
    if (act == ACT_LOAD && gen_live < POOL_DEPTH) begin
      gen_live++;
    end else if (act == ACT_DRAW && gen_live > 0) begin
      gen_live--;
    end
  endtask

  // Random contents for every field; the fields that the action ignores are random too.
  task automatic push_random(input logic act, input logic drain);
    logic [RATING_W-1:0] rating;
    logic [RAND_W-1:0]   rnd;
    int unsigned         pick;
    rating = ($urandom_range(0, 9) == 0) ? RATING_W'($urandom_range(101, 127))
                                         : RATING_W'($urandom_range(0, 100));
    pick = $urandom_range(0, 99);
    if (pick < 15) begin
      rnd = RAND_W'($urandom_range(0, 15));
    end else if (pick < 30) begin
      rnd = {RAND_W{1'b1}} - RAND_W'($urandom_range(0, 15));
    end else begin
      rnd = $urandom;
    end
    push_op(act, $urandom, $urandom, rating, $urandom, rnd, drain);
  endtask

  // ---------------------------------------------------------------------------
  // Source driver. Each queued operation waits out its gap, then stays valid until
  // the block takes it. The expected result is computed at the accepting edge.
  // ---------------------------------------------------------------------------
  int unsigned gap_left  = 0;
  logic        gap_armed = 1'b0;

  always @(posedge clk or negedge rst_n) begin : source_driver
    logic took;
    if (!rst_n) begin
      drive_op     <= '0;
      drive_valid  <= 1'b0;
      ops_accepted <= 0;
      gap_left      = 0;
      gap_armed     = 1'b0;
    end else begin
      took = drive_valid && in_ch.ready;
      if (took) begin
        pool_replies.push_back(pool_apply(drive_op));
        ops_accepted <= ops_accepted + 1;
      end
      if (!drive_valid || took) begin
        if (!gap_armed && stim_items.size() > 0) begin
          gap_left  = stim_items[0].gap;
          gap_armed = 1'b1;
        end
        if (gap_armed && gap_left > 0) begin
          gap_left--;
          drive_valid <= 1'b0;
        end else if (gap_armed &&
                     !(stim_items[0].drain && (took || ops_accepted != results_seen))) begin
          // A draining operation only goes out once the block has answered everything.
          drive_op    <= stim_items.pop_front();
          drive_valid <= 1'b1;
          gap_armed    = 1'b0;
        end else begin
          drive_valid <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Result monitor. After each result the sink draws a random stall, which may be zero;
  // every 64 results it chooses anew whether to run a stretch without any stalling.
  // ---------------------------------------------------------------------------
  int unsigned stall_left = 0;
  logic        quiet_sink = 1'b0;

  always @(posedge clk or negedge rst_n) begin : result_monitor
    result_t want;
    if (!rst_n) begin
      sink_ready   <= 1'b0;
      results_seen <= 0;
      stall_left    = 0;
    end else begin
      if (out_ch.valid && sink_ready) begin
        results_seen <= results_seen + 1;
        if (results_seen >= ops_accepted) begin
          if (mismatches < 10) begin
            $display("[%0t] result without a pending transaction: status %0d remaining %0d",
                     $realtime, out_ch.status, out_ch.remaining);
          end
          mismatches++;
        end else begin
          want = pool_replies.pop_front();
          if (out_ch.status !== want.status || out_ch.user_out !== want.rec.user ||
              out_ch.item_out !== want.rec.item || out_ch.rating_out !== want.rec.rating ||
              out_ch.time_out !== want.rec.stamp || out_ch.remaining !== want.remaining) begin
            if (mismatches < 10) begin
              $display("[%0t] result %0d mismatch (expected / actual):", $realtime,
                       results_seen);
              $display("  status %0d / %0d  remaining %0d / %0d", want.status,
                       out_ch.status, want.remaining, out_ch.remaining);
              $display("  user %h / %h  item %h / %h", want.rec.user, out_ch.user_out,
                       want.rec.item, out_ch.item_out);
              $display("  rating %0d / %0d  stamp %h / %h", want.rec.rating,
                       out_ch.rating_out, want.rec.stamp, out_ch.time_out);
            end
            mismatches++;
          end
        end
        if (results_seen % 64 == 0) begin
          quiet_sink = ($urandom_range(0, 3) == 0);
        end
        stall_left = quiet_sink ? 0 : $urandom_range(0, 15);
        sink_ready <= (stall_left == 0);
      end else if (!sink_ready) begin
        if (stall_left <= 1) begin
          stall_left = 0;
          sink_ready <= 1'b1;
        end else begin
          stall_left--;
        end
      end
    end
  end

  // The watchdog counts cycles in which neither channel completes a transaction.
  always @(posedge clk) begin
    if (!rst_n || (drive_valid && in_ch.ready) || (out_ch.valid && sink_ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      timed_out <= 1'b1;
    end
  end

  // ---------------------------------------------------------------------------
  // Sequencer: builds the whole stimulus, releases reset and waits for the end.
  // ---------------------------------------------------------------------------
  initial begin : sequencer
    int unsigned i;
    int unsigned load_pct;

    // Directed part. A draw from the empty pool comes first, with load fields set
    // to show that they are ignored.
    gap_mode = GAP_RANDOM;
    push_op(ACT_DRAW, '1, '1, '1, '1, '1, 1'b0);
    // Field extremes on loads, including ratings just above and far above the range.
    push_op(ACT_LOAD, '0, '0, 7'd0, '0, '1, 1'b0);
    push_op(ACT_LOAD, '1, '1, 7'd127, '1, '0, 1'b0);
    push_op(ACT_LOAD, 32'h8000_0001, 32'h7FFF_FFFE, 7'd100, 32'h5555_AAAA, $urandom, 1'b0);
    push_op(ACT_LOAD, 32'h0000_0001, 32'hFFFF_FFFE, 7'd101, 32'hAAAA_5555, $urandom, 1'b0);
    // Draws with the smallest and largest random words and ignored load fields.
    push_op(ACT_DRAW, '1, '1, '1, '1, '0, 1'b0);
    push_op(ACT_DRAW, '0, '0, '0, '0, '1, 1'b0);
    push_op(ACT_DRAW, $urandom, $urandom, 7'd55, $urandom, 32'h8000_0000, 1'b0);
    for (i = 0; i < 6; i++) begin
      push_random(ACT_LOAD, 1'b0);
    end
    // A draw that picks the last slot, so the move is onto itself.
    push_op(ACT_DRAW, '0, '0, '0, '0, RAND_W'(gen_live - 1), 1'b0);
    // Empty the pool, then draw from it and reload once.
    while (gen_live > 0) begin
      push_random(ACT_DRAW, 1'b0);
    end
    push_random(ACT_DRAW, 1'b0);
    push_random(ACT_LOAD, 1'b0);
    push_random(ACT_DRAW, 1'b0);

    // Random part in phases of 100 transactions with their own load share and gap
    // style. Every 250 transactions the source waits for all results first.
    for (i = 0; i < RANDOM_OPS; i++) begin
      if (i % 100 == 0) begin
        case ($urandom_range(0, 4))
          0:       load_pct = 25;
          1, 2:    load_pct = 50;
          3:       load_pct = 75;
          default: load_pct = 90;
        endcase
        gap_mode = ($urandom_range(0, 3) == 0) ? GAP_NONE : GAP_RANDOM;
      end
      push_random(($urandom_range(0, 99) < load_pct) ? ACT_LOAD : ACT_DRAW,
                  (i % 250 == 249));
    end

    // A few last transactions with sparse gaps, the first one after a full drain.
    gap_mode = GAP_SPARSE;
    push_random(ACT_DRAW, 1'b1);
    push_random(ACT_LOAD, 1'b0);
    push_random(ACT_DRAW, 1'b0);
    push_random(ACT_DRAW, 1'b0);

    ops_total = stim_items.size();

    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    while (!timed_out && !(ops_accepted == ops_total && results_seen == ops_total)) begin
      @(posedge clk);
    end
    if (!timed_out) begin
      repeat (TAIL_CYCLES) @(posedge clk);
    end

    if (timed_out) begin
      $display("TB_ERROR");
    end else if (mismatches == 0 && pool_replies.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
